@@ rtl/core/b64e_pkg.sv @@
package b64e_pkg;

   localparam int CharWidth = 8;
   localparam int MaxChars  = 6;
   localparam int IdxWidth  = $clog2(MaxChars);
   localparam int ColWidth  = 7;
   localparam int QueueDepth = 2;
   localparam int QPtrWidth = $clog2(QueueDepth);
   localparam int QCntWidth = $clog2(QueueDepth + 1);

   // Group phase codes: bytes already taken in the current group.
   localparam logic [1:0] PHASE_START = 2'd0;
   localparam logic [1:0] PHASE_ONE   = 2'd1;
   localparam logic [1:0] PHASE_TWO   = 2'd2;

   localparam logic [ColWidth-1:0] LINE_CHARS = 7'd76;

   localparam logic [CharWidth-1:0] PAD_CHAR = 8'h3d;
   localparam logic [CharWidth-1:0] CR_CHAR  = 8'h0d;
   localparam logic [CharWidth-1:0] LF_CHAR  = 8'h0a;

   // One classified input byte: the characters it yields, in order.
   typedef struct packed {
      logic [MaxChars-1:0][CharWidth-1:0] chars;
      logic [IdxWidth-1:0]                last_idx;
      logic                               msg_end;
   } job_type;

   // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
   function automatic logic [CharWidth-1:0] b64_char(input logic [5:0] six);
      logic [CharWidth-1:0] code;
      if (six < 6'd26) begin
         code = 8'd65 + {2'b00, six};
      end else if (six < 6'd52) begin
         code = 8'd71 + {2'b00, six};
      end else if (six < 6'd62) begin
         code = {2'b00, six} - 8'd4;
      end else if (six == 6'd62) begin
         code = 8'd43;
      end else begin
         code = 8'd47;
      end
      return code;
   endfunction

endpackage

@@ rtl/core/b64e_req_if.sv @@
interface b64e_req_if import b64e_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] data_byte;
   logic                 final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

@@ rtl/core/b64e_rsp_if.sv @@
interface b64e_rsp_if import b64e_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CharWidth-1:0] out_char;
   logic                 out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

@@ rtl/core/b64e_front.sv @@
module b64e_front import b64e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_chan,
   input  logic       queue_full,
   output logic       push_valid,
   output job_type    push_job
);

   logic [3:0]          leftover_ff, leftover_in;
   logic [1:0]          phase_ff, phase_in;
   logic [ColWidth-1:0] column_ff, column_in;
   logic [ColWidth-1:0] col_a, col_b;
   logic [7:0]          b;
   logic                fin;

   assign req_chan.ready = !queue_full;
   assign push_valid     = req_chan.valid && !queue_full;
   assign b              = req_chan.data_byte;
   assign fin            = req_chan.final_byte;

   // column after one and after two data characters, saturating at a full line
   assign col_a = (column_ff < LINE_CHARS) ? column_ff + 7'd1 : column_ff;
   assign col_b = (col_a < LINE_CHARS) ? col_a + 7'd1 : col_a;

   always_comb begin
      push_job    = '0;
      leftover_in = leftover_ff;
      phase_in    = phase_ff;
      column_in   = column_ff;
      push_job.msg_end = fin;
      case (phase_ff)
         PHASE_ONE: begin
            push_job.chars[0] = b64_char({leftover_ff[1:0], b[7:4]});
            if (fin) begin
               push_job.chars[1] = b64_char({b[3:0], 2'b00});
               push_job.chars[2] = PAD_CHAR;
               push_job.last_idx = 3'd2;
            end else begin
               push_job.last_idx = 3'd0;
               leftover_in = b[3:0];
               phase_in    = PHASE_TWO;
               column_in   = col_a;
            end
         end
         PHASE_TWO: begin
            push_job.chars[0] = b64_char({leftover_ff, b[7:6]});
            push_job.chars[1] = b64_char(b[5:0]);
            push_job.last_idx = 3'd1;
            leftover_in = 4'd0;
            phase_in    = PHASE_START;
            column_in   = col_b;
            if (!fin && col_b >= LINE_CHARS) begin
               push_job.chars[2] = CR_CHAR;
               push_job.chars[3] = LF_CHAR;
               push_job.last_idx = 3'd3;
               column_in = '0;
            end
         end
         default: begin
            push_job.chars[0] = b64_char(b[7:2]);
            if (fin) begin
               push_job.chars[1] = b64_char({b[1:0], 4'b0000});
               push_job.chars[2] = PAD_CHAR;
               push_job.chars[3] = PAD_CHAR;
               push_job.last_idx = 3'd3;
            end else begin
               push_job.last_idx = 3'd0;
               leftover_in = {2'b00, b[1:0]};
               phase_in    = PHASE_ONE;
               column_in   = col_a;
            end
         end
      endcase
      if (fin) begin
         leftover_in = 4'd0;
         phase_in    = PHASE_START;
         column_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leftover_ff <= 4'd0;
         phase_ff    <= PHASE_START;
         column_ff   <= '0;
      end else if (push_valid) begin
         leftover_ff <= leftover_in;
         phase_ff    <= phase_in;
         column_ff   <= column_in;
      end
   end

endmodule

@@ rtl/core/b64e_queue.sv @@
module b64e_queue import b64e_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type              slots_ff [QueueDepth];
   logic [QPtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntWidth-1:0] count_ff, count_in;
   logic                 do_pop;

   assign full       = (count_ff == QCntWidth'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_job   = slots_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ rtl/core/b64e_back.sv @@
module b64e_back import b64e_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      head_valid,
   input  job_type   head_job,
   output logic      pop,
   b64e_rsp_if.source rsp_chan
);

   job_type              cur_ff, cur_in;
   logic                 cur_valid_ff, cur_valid_in;
   logic [IdxWidth-1:0]  idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0] rsp_char_ff;
   logic                 rsp_last_ff;
   logic                 out_free, emit, done;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign emit     = cur_valid_ff && out_free;
   assign done     = emit && (idx_ff == cur_ff.last_idx);
   assign pop      = head_valid && (!cur_valid_ff || done);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_in       = head_job;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_char_ff <= cur_ff.chars[idx_ff];
         rsp_last_ff <= done && cur_ff.msg_end;
      end
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_char = rsp_char_ff;
   assign rsp_chan.out_last = rsp_last_ff;

endmodule

@@ rtl/core/base64_line_wrapped_encoder.sv @@
// An accepted byte goes into the job queue, then into the serializer's job register, and its
// characters leave through the output register. Output: one character beat per cycle, set by
// the serializer and its output register, while the receiver is ready; a byte yields 1 to 4 chars.
// Input accepts a byte every cycle while the two-entry job queue has room.
// Reset: synchronous, active high; clears group, leftover and column state and empties the queue.
module base64_line_wrapped_encoder import b64e_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   b64e_req_if.sink   req_chan,
   b64e_rsp_if.source rsp_chan
);

   // Front end: classify each byte against the group phase and line column,
   // turning it into a job that lists every character it yields.
   logic    push_valid;
   job_type push_job;
   logic    queue_full;

   // Queue head toward the serializer.
   logic    head_valid;
   job_type head_job;
   logic    pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   // Decouple: hold jobs while the output side stalls, so the front keeps taking beats.
   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Back end: advance through each job into the output register, one character beat per
   // cycle while that register is free; the next job is loaded in the cycle the current one ends.
   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

@@ tb/base64_line_wrapped_encoder_test.sv @@
module base64_line_wrapped_encoder_test import b64e_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QuietLimit  = 3000;  // cycles with no beat on either channel
   localparam int HoldCycles  = 80;    // long receiver hold-off to back up the job queue
   localparam int DrainCycles = 20;    // settle time after the last expected character
   localparam int PhaseBytes  = 135;   // random bytes per idling phase

   typedef struct packed {
      logic [CharWidth-1:0] code;
      logic                 is_last;
   } b64_char_type;

   typedef logic [7:0] byte_q_type [$];

   // Predicts the character stream of the encoder and checks what comes out.
   class b64_line_model;
      string      alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      logic [3:0] leftover;
      logic [1:0] phase;
      logic [ColWidth-1:0] column;
      b64_char_type pending_chars [$];
      int         mismatch_count;

      function new();
         clear_state();
         mismatch_count = 0;
      endfunction

      function void clear_state();
         leftover = '0;
         phase    = PHASE_START;
         column   = '0;
      endfunction

      function void push_char(logic [CharWidth-1:0] code, logic is_last);
         b64_char_type c;
         c.code    = code;
         c.is_last = is_last;
         pending_chars.push_back(c);
      endfunction

      function void push_data(logic [5:0] six, logic is_last);
         push_char(alphabet[six], is_last);
         if (column < LINE_CHARS) column++;
      endfunction

      // Note one accepted byte and queue the characters it yields.
      function void take_byte(logic [7:0] b, logic fin);
         case (phase)
            PHASE_ONE: begin
               push_data({leftover[1:0], b[7:4]}, 1'b0);
               if (fin) begin
                  push_data({b[3:0], 2'b00}, 1'b0);
                  push_char(PAD_CHAR, 1'b1);
               end else begin
                  leftover = b[3:0];
                  phase    = PHASE_TWO;
               end
            end
            PHASE_TWO: begin
               push_data({leftover, b[7:6]}, 1'b0);
               push_data(b[5:0], fin);
               if (!fin) begin
                  // wrap only between groups, and never after the message end
                  if (column >= LINE_CHARS) begin
                     push_char(CR_CHAR, 1'b0);
                     push_char(LF_CHAR, 1'b0);
                     column = '0;
                  end
                  leftover = '0;
                  phase    = PHASE_START;
               end
            end
            default: begin
               push_data(b[7:2], 1'b0);
               if (fin) begin
                  push_data({b[1:0], 4'b0000}, 1'b0);
                  push_char(PAD_CHAR, 1'b0);
                  push_char(PAD_CHAR, 1'b1);
               end else begin
                  leftover = {2'b00, b[1:0]};
                  phase    = PHASE_ONE;
               end
            end
         endcase
         if (fin) clear_state();
      endfunction

      task report_mismatch(string what);
         $display("%0t ns: mismatch: %s", $time, what);
         mismatch_count++;
      endtask

      task match_char(logic [CharWidth-1:0] code, logic is_last);
         b64_char_type want;
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h last=%0b", code, is_last));
         end else begin
            want = pending_chars.pop_front();
            if (code !== want.code)
               report_mismatch($sformatf("out_char 0x%02h, want 0x%02h", code, want.code));
            if (is_last !== want.is_last)
               report_mismatch($sformatf("out_last %0b, want %0b (char 0x%02h)",
                                         is_last, want.is_last, want.code));
         end
      endtask

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   b64e_req_if req_chan ();
   b64e_rsp_if rsp_chan ();

   b64_line_model char_stream = new();

   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   bit hold_rsp_req  = 1'b0;
   int quiet_cycles  = 0;

   base64_line_wrapped_encoder u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   // Offer one byte; hold it until the block takes it, then return on the
   // following falling edge so the next beat can follow back to back.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid      = 1'b1;
      req_chan.data_byte  = b;
      req_chan.final_byte = fin;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic send_message(input byte_q_type msg);
      for (int i = 0; i < msg.size(); i++)
         send_byte(msg[i], i == msg.size() - 1);
   endtask

   // Receiver: random stalls at the current rate, or a long hold-off on request.
   initial begin
      int hold_left;
      hold_left      = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (hold_rsp_req) begin
            hold_rsp_req   = 1'b0;
            hold_left      = HoldCycles - 1;
            rsp_chan.ready = 1'b0;
         end else begin
            rsp_chan.ready = ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // Sample both channels at the rising edge; feed the predictor with every
   // accepted byte, check every accepted character, and watch for a hang.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            char_stream.take_byte(req_chan.data_byte, req_chan.final_byte);
         if (rsp_chan.valid && rsp_chan.ready)
            char_stream.match_char(rsp_chan.out_char, rsp_chan.out_last);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $display("%0t ns: timeout, %0d chars still expected", $time, char_stream.pending());
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      byte_q_type msg;
      int         sent;
      int         len;
      clock               = 1'b0;
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.data_byte  = '0;
      req_chan.final_byte = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // First idling mix: sender mostly busy, receiver mostly stalled.
      send_idle_pct = 15;
      rsp_idle_pct  = 73;

      // Directed: one-, two- and three-byte messages at both byte extremes
      // (both pad forms and a full group), then four and five bytes so a
      // message ends right after a full group and the next one starts clean.
      send_message('{8'h00});
      send_message('{8'hff});
      send_message('{8'h00, 8'hff});
      send_message('{8'hff, 8'h00});
      send_message('{8'h00, 8'h00, 8'h00});
      send_message('{8'hff, 8'hff, 8'hff});
      send_message('{8'h4d, 8'h61, 8'h6e, 8'hfb});
      send_message('{8'hf8, 8'h3e, 8'h0f, 8'hbf, 8'hfe});

      for (int mix = 0; mix < 3; mix++) begin
         case (mix)
            0: begin
               send_idle_pct = 15;
               rsp_idle_pct  = 73;
            end
            1: begin
               send_idle_pct = 73;
               rsp_idle_pct  = 15;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct  = 0;
               // stall the output while bytes keep coming, to fill the queue
               hold_rsp_req  = 1'b1;
            end
         endcase
         sent = 0;
         while (sent < PhaseBytes) begin
            // Mostly short messages; some long enough to wrap, a few ending
            // exactly on a full line so no line break may follow the end.
            case ($urandom_range(0, 9))
               0:       len = ($urandom_range(0, 1) == 0) ? 57 : 114;
               1, 2:    len = $urandom_range(55, 130);
               default: len = $urandom_range(1, 6);
            endcase
            // trim the last message so each phase sends its byte budget exactly
            if (len > PhaseBytes - sent) len = PhaseBytes - sent;
            msg.delete();
            repeat (len) msg.push_back(8'($urandom_range(0, 255)));
            send_message(msg);
            sent += len;
         end
      end
      req_chan.valid = 1'b0;

      // Drain: wait for every expected character, then let the block settle.
      while (char_stream.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (char_stream.mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
